// File: rtl/owrgb_pkg.sv
// shared types and constants for the one-wire rgb pulse encoder
`default_nettype none

package owrgb_pkg;

    localparam int TIMER_W    = 10;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int LEVEL_W    = 8;
    localparam int FRAME_BITS = 3 * LEVEL_W;
    localparam int BITCNT_W   = $clog2(FRAME_BITS + 1);

    typedef logic [TIMER_W-1:0]    timer_t;
    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [BITCNT_W-1:0]   bitcnt_t;

    // line phases
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } phase_t;

    // opcodes
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } opcode_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd4;

    // reset values of the timing registers
    localparam timer_t RST_RESET_LOW = timer_t'(50);
    localparam timer_t RST_ONE_HIGH  = timer_t'(20);
    localparam timer_t RST_ONE_LOW   = timer_t'(10);
    localparam timer_t RST_ZERO_HIGH = timer_t'(10);
    localparam timer_t RST_ZERO_LOW  = timer_t'(20);

endpackage

`default_nettype wire

// File: rtl/one_wire_rgb_pulse_encoder.sv
// top level of the one-wire rgb pulse encoder
`default_nettype none

// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+----------------------------------------
// s_        | in        | s_valid / s_ready | s_opcode, s_red_level, s_blue_level,
//           |           |                   | s_green_level
// m_        | out       | m_valid / m_ready | m_line_level, m_busy_res, m_frame_done
// cfg_      | in        | cfg_we            | cfg_index, cfg_data
//
// one transaction in gives one transaction out; the line state advances in the
// same cycle the input is taken and the result sits in the output register.
// throughput is one transaction per cycle while the output is not stalled; the result is registered.
// s_ready drops only while a result is held and m_ready is low.
// aresetn is synchronous, active low: line idle, timing registers to defaults.

module one_wire_rgb_pulse_encoder (
    input  wire                                  aclk,
    input  wire                                  aresetn,

    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire                                  s_opcode,
    input  wire  [owrgb_pkg::LEVEL_W-1:0]        s_red_level,
    input  wire  [owrgb_pkg::LEVEL_W-1:0]        s_blue_level,
    input  wire  [owrgb_pkg::LEVEL_W-1:0]        s_green_level,

    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic                                 m_line_level,
    output logic                                 m_busy_res,
    output logic                                 m_frame_done,

    input  wire                                  cfg_we,
    input  wire  [owrgb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [owrgb_pkg::CFG_W-1:0]          cfg_data
);

    // timing registers
    owrgb_pkg::timer_t reset_low_reg, one_high_reg, one_low_reg;
    owrgb_pkg::timer_t zero_high_reg, zero_low_reg;
    owrgb_pkg::timer_t cfg_value;

    // line state
    owrgb_pkg::phase_t  phase_reg,  phase_next;
    owrgb_pkg::timer_t  timer_reg,  timer_next;
    owrgb_pkg::frame_t  shift_reg,  shift_next;
    owrgb_pkg::bitcnt_t bits_reg,   bits_next;
    logic               done_next;

    // result register
    logic m_valid_reg, line_reg, busy_reg, done_reg;
    logic line_next, busy_next;

    logic    s_fire;
    logic    top_bit, next_top_bit;
    owrgb_pkg::bitcnt_t bits_dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign cfg_value = owrgb_pkg::timer_t'(cfg_data);

    // configuration writes, out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg <= owrgb_pkg::RST_RESET_LOW;
            one_high_reg  <= owrgb_pkg::RST_ONE_HIGH;
            one_low_reg   <= owrgb_pkg::RST_ONE_LOW;
            zero_high_reg <= owrgb_pkg::RST_ZERO_HIGH;
            zero_low_reg  <= owrgb_pkg::RST_ZERO_LOW;
        end else if (cfg_we) begin
            unique case (cfg_index)
                owrgb_pkg::REG_RESET_LOW: reset_low_reg <= cfg_value;
                owrgb_pkg::REG_ONE_HIGH:  one_high_reg  <= cfg_value;
                owrgb_pkg::REG_ONE_LOW:   one_low_reg   <= cfg_value;
                owrgb_pkg::REG_ZERO_HIGH: zero_high_reg <= cfg_value;
                owrgb_pkg::REG_ZERO_LOW:  zero_low_reg  <= cfg_value;
                default: ;
            endcase
        end
    end

    // current bit and the bit after the shift
    assign top_bit      = shift_reg[owrgb_pkg::FRAME_BITS-1];
    assign next_top_bit = shift_reg[owrgb_pkg::FRAME_BITS-2];
    assign bits_dec     = bits_reg - owrgb_pkg::bitcnt_t'(1);

    // next state; a timer at zero behaves like one tick
    always_comb begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        done_next  = 1'b0;
        if (s_opcode == owrgb_pkg::OP_START) begin
            // start only lands while idle
            if (phase_reg == owrgb_pkg::PH_IDLE) begin
                shift_next = {s_red_level, s_blue_level, s_green_level};
                bits_next  = owrgb_pkg::bitcnt_t'(owrgb_pkg::FRAME_BITS);
                phase_next = owrgb_pkg::PH_RESET;
                timer_next = reset_low_reg;
            end
        end else if (timer_reg > owrgb_pkg::timer_t'(1)) begin
            if (phase_reg != owrgb_pkg::PH_IDLE) begin
                timer_next = timer_reg - owrgb_pkg::timer_t'(1);
            end
        end else begin
            unique case (phase_reg)
                owrgb_pkg::PH_IDLE: ;
                owrgb_pkg::PH_RESET: begin
                    phase_next = owrgb_pkg::PH_HIGH;
                    timer_next = top_bit ? one_high_reg : zero_high_reg;
                end
                owrgb_pkg::PH_HIGH: begin
                    phase_next = owrgb_pkg::PH_LOW;
                    timer_next = top_bit ? one_low_reg : zero_low_reg;
                end
                owrgb_pkg::PH_LOW: begin
                    shift_next = {shift_reg[owrgb_pkg::FRAME_BITS-2:0], 1'b0};
                    bits_next  = bits_dec;
                    if (bits_dec == '0) begin
                        phase_next = owrgb_pkg::PH_IDLE;
                        timer_next = '0;
                        done_next  = 1'b1;
                    end else begin
                        phase_next = owrgb_pkg::PH_HIGH;
                        timer_next = next_top_bit ? one_high_reg : zero_high_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields follow the phase after this transaction
    always_comb begin
        line_next = 1'b1;
        busy_next = 1'b1;
        unique case (phase_next)
            owrgb_pkg::PH_IDLE:  busy_next = 1'b0;
            owrgb_pkg::PH_RESET: line_next = 1'b0;
            owrgb_pkg::PH_HIGH:  line_next = 1'b1;
            owrgb_pkg::PH_LOW:   line_next = 1'b0;
            default: ;
        endcase
    end

    // state updates on every accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= owrgb_pkg::PH_IDLE;
            timer_reg <= '0;
            shift_reg <= '0;
            bits_reg  <= '0;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
        end
    end

    // output register, held while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            line_reg <= line_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line_level = line_reg;
    assign m_busy_res   = busy_reg;
    assign m_frame_done = done_reg;

    // a running frame always has bits left, an idle line has none
    a_bits_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != owrgb_pkg::PH_IDLE) |-> (bits_reg != '0))
        else $error("frame running with no bits left");

    a_bits_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == owrgb_pkg::PH_IDLE) |-> (bits_reg == '0))
        else $error("idle line with bits pending");

    // a start on an idle line loads a full frame into reset-low
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_opcode == owrgb_pkg::OP_START && phase_reg == owrgb_pkg::PH_IDLE)
        |=> (phase_reg == owrgb_pkg::PH_RESET
             && bits_reg == owrgb_pkg::bitcnt_t'(owrgb_pkg::FRAME_BITS)))
        else $error("start did not load the frame");

    // line state only moves on an accepted transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> ($stable(phase_reg) && $stable(shift_reg) && $stable(timer_reg)))
        else $error("line state moved without a transaction");

    // frame_done only comes with the line back to idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> (!m_busy_res && m_line_level))
        else $error("frame_done while busy");

endmodule

`default_nettype wire
